// ===== rtl/svde_pkg.sv =====
// ----------------------------------------------------------------------------
// svde_pkg: shared types and constants of the sample delta varint encoder
// Holds the payload structs, the queue entry and the back-end state codes.
// ----------------------------------------------------------------------------
package svde_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned QUEUE_CNT_W = 2;

	// Register index of record_type_code.
	localparam logic [APB_AW-3:0] REG_TYPE_CODE = '0;

	typedef struct packed {
		logic [WORD_W-1:0]        series_ref;
		logic signed [WORD_W-1:0] timestamp;
		logic [WORD_W-1:0]        value_bits;
		logic [WORD_W-1:0]        txn_id;
		logic                     first_of_batch;
	} sample_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_byte;
	} result_t;

	// One classified sample. For a batch start the words are the raw fields,
	// otherwise w0, w1 and w3 hold zigzag-mapped differences.
	typedef struct packed {
		logic              first;
		logic [BYTE_W-1:0] type_code;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		logic [WORD_W-1:0] w3;
	} entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TYPE = 6'b000010,
		ST_W0   = 6'b000100,
		ST_W1   = 6'b001000,
		ST_W2   = 6'b010000,
		ST_W3   = 6'b100000
	} back_state_t;

	function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] d);
		return {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
	endfunction

endpackage

// ===== rtl/svde_front.sv =====
// ----------------------------------------------------------------------------
// svde_front: sample intake and classification
// Takes a sample, forms the zigzag-mapped differences against the previous
// sample and pushes the classified entry into the queue.
// ----------------------------------------------------------------------------
module svde_front import svde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sample_t           in_data,
	input  logic [BYTE_W-1:0] type_code,
	input  queue_status_t     q_status,
	output logic              push,
	output entry_t            push_data
);

	logic [WORD_W-1:0] prev_ref_q;
	logic [WORD_W-1:0] prev_time_q;
	logic [WORD_W-1:0] prev_txn_q;
	logic [WORD_W-1:0] d_ref;
	logic [WORD_W-1:0] d_time;
	logic [WORD_W-1:0] d_txn;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	// Differences wrap modulo 2^64; the timestamp is taken as raw bits.
	assign d_ref  = in_data.series_ref - prev_ref_q;
	assign d_time = $unsigned(in_data.timestamp) - prev_time_q;
	assign d_txn  = in_data.txn_id - prev_txn_q;

	always_comb begin
		push_data.first     = in_data.first_of_batch;
		push_data.type_code = type_code;
		push_data.w2        = in_data.value_bits;
		if (in_data.first_of_batch) begin
			push_data.w0 = in_data.series_ref;
			push_data.w1 = $unsigned(in_data.timestamp);
			push_data.w3 = in_data.txn_id;
		end else begin
			push_data.w0 = zigzag(d_ref);
			push_data.w1 = zigzag(d_time);
			push_data.w3 = zigzag(d_txn);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ref_q  <= '0;
			prev_time_q <= '0;
			prev_txn_q  <= '0;
		end else if (push) begin
			prev_ref_q  <= in_data.series_ref;
			prev_time_q <= $unsigned(in_data.timestamp);
			prev_txn_q  <= in_data.txn_id;
		end
	end

endmodule

// ===== rtl/svde_queue.sv =====
// ----------------------------------------------------------------------------
// svde_queue: two-entry queue between front and back end
// Lets the front take a new sample while the back still serializes one.
// ----------------------------------------------------------------------------
module svde_queue import svde_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  entry_t        push_data,
	input  logic          pop,
	output queue_status_t status,
	output entry_t        head
);

	entry_t                 mem_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign status.full  = (count_q == QUEUE_CNT_W'(2));
	assign status.valid = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/svde_back.sv =====
// ----------------------------------------------------------------------------
// svde_back: byte serializer
// Walks the segments of one entry and drives one byte per unstalled cycle into
// the output register: type byte, fixed big-endian words or LSB-first varints.
// ----------------------------------------------------------------------------
module svde_back import svde_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_status,
	input  entry_t        head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output result_t       out_data
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic              first_q;
	logic [BYTE_W-1:0] type_q;
	logic [WORD_W-1:0] w1_q;
	logic [WORD_W-1:0] w2_q;
	logic [WORD_W-1:0] w3_q;
	logic [WORD_W-1:0] sh_q;
	logic [WORD_W-1:0] sh_d;
	logic [2:0]        cnt_q;
	logic [2:0]        cnt_d;
	logic              out_valid_q;
	result_t           out_q;
	logic              adv;
	logic              emit;
	logic              fixed;
	logic              seg_done;
	logic              more;
	logic [BYTE_W-1:0] byte_d;
	logic              last_d;

	assign adv   = !out_valid_q || out_ready;
	assign emit  = adv && (state_q != ST_IDLE);
	assign fixed = first_q || (state_q == ST_W2);
	assign more  = |sh_q[WORD_W-1:7];

	always_comb begin
		state_d  = state_q;
		sh_d     = sh_q;
		cnt_d    = cnt_q;
		byte_d   = '0;
		last_d   = 1'b0;
		seg_done = 1'b0;
		pop      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop = q_status.valid;
			end
			ST_TYPE: begin
				byte_d = type_q;
				if (adv) begin
					state_d = ST_W0;
				end
			end
			ST_W0, ST_W1, ST_W2, ST_W3: begin
				if (fixed) begin
					byte_d   = sh_q[WORD_W-1 -: BYTE_W];
					seg_done = (cnt_q == 3'd7);
				end else begin
					byte_d   = {more, sh_q[6:0]};
					seg_done = !more;
				end
				if (emit) begin
					sh_d  = fixed ? {sh_q[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}}
					              : {7'd0, sh_q[WORD_W-1:7]};
					cnt_d = cnt_q + 3'd1;
					if (seg_done) begin
						cnt_d = '0;
						unique case (state_q)
							ST_W0: begin
								state_d = ST_W1;
								sh_d    = w1_q;
							end
							ST_W1: begin
								state_d = ST_W2;
								sh_d    = w2_q;
							end
							ST_W2: begin
								state_d = ST_W3;
								sh_d    = w3_q;
							end
							default: begin
								// Final segment: take the next entry straight away.
								last_d  = 1'b1;
								state_d = ST_IDLE;
								pop     = q_status.valid;
							end
						endcase
					end
				end else begin
					last_d = seg_done && (state_q == ST_W3);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (pop) begin
			state_d = head.first ? ST_TYPE : ST_W0;
			sh_d    = head.w0;
			cnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		sh_q  <= sh_d;
		cnt_q <= cnt_d;
		if (pop) begin
			first_q <= head.first;
			type_q  <= head.type_code;
			w1_q    <= head.w1;
			w2_q    <= head.w2;
			w3_q    <= head.w3;
		end
		if (emit) begin
			out_q.out_byte  <= byte_d;
			out_q.last_byte <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/sample_delta_varint_encoder_top.sv =====
// A sample accepted at an idle block goes through the queue and the serializer
// registers to the output register. The output carries one byte per cycle unless
// stalled or empty; a sample is 33 bytes at a batch start and 11 to 38 otherwise.
// A two-entry queue lets the next samples be taken while a sample is serialized.
// Reset is asynchronous: previous fields and record_type_code clear to zero,
// the queue and output empty; no clearing pass follows.
// ----------------------------------------------------------------------------
// sample_delta_varint_encoder_top: delta, zigzag and varint sample encoder
// Turns time-series samples into an encoded byte stream with an APB register
// for the batch record type byte.
// ----------------------------------------------------------------------------
module sample_delta_varint_encoder_top import svde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sample_t           in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [BYTE_W-1:0] type_code_q;
	logic              reg_hit;
	logic              push;
	entry_t            push_data;
	logic              pop;
	queue_status_t     q_status;
	entry_t            head;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_TYPE_CODE);
	assign prdata  = reg_hit ? {{(APB_DW-BYTE_W){1'b0}}, type_code_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_code_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			type_code_q <= pwdata[BYTE_W-1:0];
		end
	end

	svde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.type_code (type_code_q),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	svde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.status    (q_status),
		.head      (head)
	);

	svde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/svde_checker.sv =====
// ----------------------------------------------------------------------------
// svde_checker: port-level checks of the encoder
// Watches the handshakes and the register port of the top level.
// ----------------------------------------------------------------------------
module svde_checker import svde_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input result_t           out_data,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata
);

	// The output register is empty while reset is held.
	a_out_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// A stalled transfer keeps valid high.
	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the transfer");

	// A stalled transfer keeps its payload.
	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// A write to the type register is read back on the following cycle.
	a_type_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_TYPE_CODE)
		|=> (paddr[APB_AW-1:2] != REG_TYPE_CODE)
			|| (prdata[BYTE_W-1:0] == $past(pwdata[BYTE_W-1:0])))
		else $error("record type register readback mismatch");

endmodule

bind sample_delta_varint_encoder_top svde_checker u_svde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

// ===== verif/svde_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svde_stream_checker: byte stream checker for the sample delta varint encoder
// Watches the sample, byte and register ports. For every sample transfer it
// works out the encoded bytes, then compares each byte transfer in order
// against them. It also checks register read data.
// ----------------------------------------------------------------------------
module svde_stream_checker import svde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  sample_t           in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  result_t           out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	output int                err_cnt,
	output int                pending_cnt
);

	logic [BYTE_W-1:0] type_code;
	logic [WORD_W-1:0] prev_ref;
	logic [WORD_W-1:0] prev_time;
	logic [WORD_W-1:0] prev_txn;
	result_t           pending_bytes[$];
	logic [BYTE_W-1:0] enc_buf [0:37];
	int                enc_len;
	int                mismatches;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic add_byte(input logic [BYTE_W-1:0] b);
		enc_buf[enc_len] = b;
		enc_len++;
	endtask

	task automatic add_fixed(input logic [WORD_W-1:0] w);
		for (int k = 7; k >= 0; k--)
			add_byte(w[k*8 +: 8]);
	endtask

	// Zigzag maps the wrapped difference, then 7-bit groups go out LSB first.
	task automatic add_varint(input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] z;
		z = {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
		while (z >= 64'h80) begin
			add_byte({1'b1, z[6:0]});
			z = z >> 7;
		end
		add_byte(z[BYTE_W-1:0]);
	endtask

	task automatic encode_sample(input sample_t s);
		result_t r;
		enc_len = 0;
		if (s.first_of_batch) begin
			add_byte(type_code);
			add_fixed(s.series_ref);
			add_fixed(s.timestamp);
			add_fixed(s.value_bits);
			add_fixed(s.txn_id);
		end else begin
			add_varint(s.series_ref - prev_ref);
			add_varint(s.timestamp - prev_time);
			add_fixed(s.value_bits);
			add_varint(s.txn_id - prev_txn);
		end
		for (int i = 0; i < enc_len; i++) begin
			r.out_byte  = enc_buf[i];
			r.last_byte = (i == enc_len - 1);
			pending_bytes.insert(pending_bytes.size(), r);
		end
		prev_ref  = s.series_ref;
		prev_time = s.timestamp;
		prev_txn  = s.txn_id;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			type_code  = '0;
			prev_ref   = '0;
			prev_time  = '0;
			prev_txn   = '0;
			mismatches = 0;
			pending_bytes.delete();
			err_cnt     <= 0;
			pending_cnt <= 0;
		end else begin
			// A sample passes through registers before it reaches the output, so the byte
			// side is handled before a sample of the same edge is queued.
			if (out_valid && out_ready) begin
				if (pending_bytes.size() == 0) begin
					report_mismatch("unexpected byte", 32'(out_data), '0);
				end else begin
					want = pending_bytes.pop_front();
					if (out_data.out_byte != want.out_byte)
						report_mismatch("out_byte", 32'(out_data.out_byte),
							32'(want.out_byte));
					if (out_data.last_byte != want.last_byte)
						report_mismatch("last_byte", 32'(out_data.last_byte),
							32'(want.last_byte));
				end
			end
			if (in_valid && in_ready)
				encode_sample(in_data);
			if (psel && penable && pready && paddr[APB_AW-1:2] == REG_TYPE_CODE) begin
				if (pwrite)
					type_code = pwdata[BYTE_W-1:0];
				else if (prdata != {{(APB_DW-BYTE_W){1'b0}}, type_code})
					report_mismatch("record_type_code read", prdata,
						{{(APB_DW-BYTE_W){1'b0}}, type_code});
			end
			err_cnt     <= mismatches;
			pending_cnt <= pending_bytes.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sample delta varint encoder
// Sends directed edge samples and random batches of samples under random
// source and sink stalls, changes the record type byte between phases, and
// lets the checker compare the byte stream.
// ----------------------------------------------------------------------------
module tb_top;
	import svde_pkg::*;

	localparam logic [APB_AW-1:0] TYPE_CODE_ADDR = {REG_TYPE_CODE, 2'b00};
	localparam logic [APB_AW-1:0] NO_REG_ADDR    = TYPE_CODE_ADDR + 3'd4;
	localparam int                WATCHDOG_LIMIT = 2000;
	localparam int                SETTLE_CYCLES  = 8;
	localparam int                PHASE_ITEMS    = 25;
	localparam logic [WORD_W-1:0] ALL_ONES       = '1;
	localparam logic [WORD_W-1:0] MAX_POS        = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [WORD_W-1:0] MIN_NEG        = 64'h8000_0000_0000_0000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	sample_t           in_data;
	logic              out_valid;
	logic              out_ready;
	result_t           out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                err_cnt;
	int                pending_cnt;
	int                idle_cycles = 0;
	logic              src_quiet;
	logic              sink_quiet;
	logic [WORD_W-1:0] gen_ref;
	logic [WORD_W-1:0] gen_time;
	logic [WORD_W-1:0] gen_txn;

	sample_delta_varint_encoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	svde_stream_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.err_cnt    (err_cnt),
		.pending_cnt(pending_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic sample_t mk_sample(input logic [WORD_W-1:0] sr, ts, vb, tx,
			input logic fb);
		sample_t s;
		s.series_ref     = sr;
		s.timestamp      = ts;
		s.value_bits     = vb;
		s.txn_id         = tx;
		s.first_of_batch = fb;
		return s;
	endfunction

	// Keeps the value or takes a small step as in real series, or a large step; two of five picks are arbitrary.
	function automatic logic [WORD_W-1:0] next_field(input logic [WORD_W-1:0] prev);
		logic [WORD_W-1:0] step;
		case ($urandom_range(0, 4))
			0: return prev;
			1: return prev + {32'd0, $urandom_range(0, 200)} - 64'd100;
			2: begin
				step = {$urandom, $urandom} >> $urandom_range(1, 62);
				return $urandom_range(0, 1) ? prev + step : prev - step;
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_sample(input sample_t s);
		int unsigned gap;
		if ($urandom_range(0, 23) == 0)
			src_quiet = !src_quiet;
		gap = src_quiet ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gen_ref  = s.series_ref;
		gen_time = s.timestamp;
		gen_txn  = s.txn_id;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_type_code(input logic [APB_DW-1:0] data);
		apb_access(1'b1, TYPE_CODE_ADDR, data);
		apb_access(1'b0, TYPE_CODE_ADDR, '0);
	endtask

	// One batch: a batch start and a run of deltas. Some batches lack the
	// start and keep encoding against whatever came before.
	task automatic send_batch(inout int sent);
		int unsigned n_delta;
		if ($urandom_range(0, 7) == 0)
			send_sample(mk_sample(next_field(gen_ref), next_field(gen_time),
				{$urandom, $urandom}, next_field(gen_txn), 1'b0));
		else
			send_sample(mk_sample({$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, 1'b1));
		sent++;
		n_delta = $urandom_range(1, 8);
		repeat (n_delta) begin
			send_sample(mk_sample(next_field(gen_ref), next_field(gen_time),
				{$urandom, $urandom}, next_field(gen_txn), 1'b0));
			sent++;
		end
	endtask

	initial begin : result_sink
		int unsigned gap;
		out_ready <= 1'b0;
		sink_quiet = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				sink_quiet = !sink_quiet;
			gap = sink_quiet ? 0 : $urandom_range(0, 15);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int sent;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		src_quiet  = 1'b0;
		gen_ref    = '0;
		gen_time   = '0;
		gen_txn    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Deltas straight after reset are taken against the all-zero state.
		send_sample(mk_sample('0, '0, '0, '0, 1'b0));
		send_sample(mk_sample(64'd1, ALL_ONES, ALL_ONES, MIN_NEG, 1'b0));
		send_sample(mk_sample(ALL_ONES, MAX_POS, MIN_NEG, ALL_ONES, 1'b1));
		drain_results();

		set_type_code(32'hFFFF_FFFF);
		// Nothing lives at this address, so the write must change nothing.
		apb_access(1'b1, NO_REG_ADDR, 32'h0000_005A);
		apb_access(1'b0, TYPE_CODE_ADDR, '0);

		// Every difference is two to the 63rd: the longest possible sample.
		send_sample(mk_sample(MAX_POS, ALL_ONES, '0, MAX_POS, 1'b0));
		send_sample(mk_sample(ALL_ONES, MIN_NEG, ALL_ONES, '0, 1'b1));
		send_sample(mk_sample('0, MAX_POS, MAX_POS, ALL_ONES, 1'b0));
		send_sample(mk_sample('0, '0, '0, '0, 1'b1));
		// Varint group boundaries around zigzag values 127 and 128.
		send_sample(mk_sample(64'd63, -64'sd64, 64'h0123_4567_89AB_CDEF, 64'd64, 1'b0));
		send_sample(mk_sample(64'd127, -64'sd128, 64'hFEDC_BA98_7654_3210,
			64'd8256, 1'b0));
		send_sample(mk_sample('0, MIN_NEG, MIN_NEG, '0, 1'b0));
		drain_results();

		set_type_code(32'h0000_0000);
		send_sample(mk_sample(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h3FF0_0000_0000_0000, 64'h5555_5555_5555_5555, 1'b1));
		send_sample(mk_sample(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'hC000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			set_type_code({$urandom});
			if (ph == 2)
				apb_access(1'b1, NO_REG_ADDR, {$urandom});
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				send_batch(sent);
				// Now and then hold the source until the stream runs dry.
				if ($urandom_range(0, 9) == 0)
					drain_results();
			end
			drain_results();
		end

		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/svde_pkg.sv
rtl/svde_front.sv
rtl/svde_queue.sv
rtl/svde_back.sv
rtl/sample_delta_varint_encoder_top.sv
rtl/svde_checker.sv
verif/svde_checker.sv
verif/tb_top.sv
